// ----- design/wth_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wth_pkg
// Shared types and constants for the word token hasher.
// ----------------------------------------------------------------------------
package wth_pkg;

    localparam int WORD_LIMIT_MAX_DEF   = 256;
    localparam int LENGTH_LIMIT_MAX_DEF = 4096;

    localparam int MAX_WORDS_W  = 9;
    localparam int MAX_LENGTH_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_ADDR_W   = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_WORDS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH = 2'd1;

    localparam logic [MAX_WORDS_W-1:0]  MAX_WORDS_RST  = 9'd256;
    localparam logic [MAX_LENGTH_W-1:0] MAX_LENGTH_RST = 13'd4096;

    localparam logic [63:0] HASH_SEED = 64'd5381;

    localparam logic RES_WORD  = 1'b0;
    localparam logic RES_COUNT = 1'b1;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // result queue depth; one input request may push two results
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic                   kind;
        logic [63:0]            hash;
        logic [MAX_WORDS_W-1:0] count;
        logic                   last;
    } t_result;

    function automatic logic is_mark_byte(input logic [7:0] b);
        return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
               (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
    endfunction

endpackage
`default_nettype wire

// ----- design/word_token_hasher_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// word_token_hasher_core
// Streams review text bytes, emits djb2 hashes of lowered words and a
// word count at the end of each review.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis  : one text byte per request in tdata[7:0], tlast marks the last
//             byte of a review.
//   m_axis  : result requests. tuser is the kind (0 word hash, 1 end of
//             review), tdata[63:0] the hash (0 on a count result),
//             tdata[72:64] the words emitted so far, tlast set on the final
//             result caused by one input byte.
//   cfg     : i_cfg_we/i_cfg_addr/i_cfg_wdata write max_words (index 0) or
//             max_length (index 1); other indexes are dropped.
// Timing:
//   Each byte is handled in the cycle it is accepted: the hash update is a
//   shift-add of the running 64-bit hash. Results are registered into the
//   result queue ahead of m_axis. One byte per cycle is sustained while
//   s_axis_tready is high; a closing byte that yields two results (word hash
//   plus count) drains one result per cycle, while m_axis_tready is high,
//   through the 4-entry result queue. s_axis_tready is low while three or
//   more results wait, so a stalled receiver backs up into the input.
// Reset:
//   Synchronous, active low. Clears the review state, the queue, and sets
//   max_words to 256 and max_length to 4096.
// ----------------------------------------------------------------------------
module word_token_hasher_core #(
    parameter int WORD_LIMIT_MAX   = wth_pkg::WORD_LIMIT_MAX_DEF,
    parameter int LENGTH_LIMIT_MAX = wth_pkg::LENGTH_LIMIT_MAX_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [wth_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [wth_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output wire logic                          s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [7:0] text_byte
    input  wire logic                          s_axis_tlast,  // end_of_text
    // result stream
    output wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output wire logic [79:0]                   m_axis_tdata,  // [63:0] word_hash,
                                                              // [72:64] words_emitted,
                                                              // [79:73] zero
    output wire logic                          m_axis_tuser,  // result_kind
    output wire logic                          m_axis_tlast   // last_of_run
);
    import wth_pkg::*;

    // compare widths wide enough for both the register and the clamp value
    localparam int WLW  = $clog2(WORD_LIMIT_MAX + 1);
    localparam int LLW  = $clog2(LENGTH_LIMIT_MAX + 1);
    localparam int WCW  = (WLW > MAX_WORDS_W)  ? WLW : MAX_WORDS_W;
    localparam int LCW  = (LLW > MAX_LENGTH_W) ? LLW : MAX_LENGTH_W;
    localparam int QLW  = $clog2(FIFO_DEPTH + 1);

    // config registers
    logic [MAX_WORDS_W-1:0]  r_max_words;
    logic [MAX_LENGTH_W-1:0] r_max_length;

    // review state
    logic [63:0]             r_hash,     n_hash;
    logic [MAX_WORDS_W-1:0]  r_word_cnt, n_word_cnt;
    logic [MAX_LENGTH_W-1:0] r_byte_cnt, n_byte_cnt;
    logic                    r_closed,   n_closed;   // NUL seen, rest ignored
    logic                    r_inside,   n_inside;

    logic                    accept;
    logic [MAX_WORDS_W-1:0]  word_lim;
    logic [MAX_LENGTH_W-1:0] len_lim;
    logic                    active;
    logic                    is_space;
    logic                    is_word_byte;
    logic [7:0]              low_byte;
    logic [63:0]             byte_ext;
    logic [63:0]             hash_mid;
    logic                    inside_mid;
    logic                    close_now;
    logic                    word_emit;
    logic [MAX_WORDS_W-1:0]  cnt_after;

    t_result                 res_word, res_count, push_d0, push_d1, q_data;
    logic [1:0]              push_n;
    logic                    q_valid;
    logic [QLW-1:0]          q_level;

    // two free entries needed: one byte may produce two results
    assign s_axis_tready = (q_level <= QLW'(FIFO_DEPTH - 2));
    assign accept        = s_axis_tvalid && s_axis_tready;

    // clamp registers to the parameter limits
    assign word_lim = (WCW'(r_max_words) > WCW'(WORD_LIMIT_MAX))
                      ? MAX_WORDS_W'(WORD_LIMIT_MAX) : r_max_words;
    assign len_lim  = (LCW'(r_max_length) > LCW'(LENGTH_LIMIT_MAX))
                      ? MAX_LENGTH_W'(LENGTH_LIMIT_MAX) : r_max_length;

    // byte classification
    always_comb begin
        active       = !r_closed && (r_byte_cnt < len_lim);
        is_space     = (s_axis_tdata == CHAR_SPACE);
        is_word_byte = (s_axis_tdata != CHAR_NUL) && !is_space && !is_mark_byte(s_axis_tdata);
        low_byte     = s_axis_tdata;
        if (s_axis_tdata >= 8'h41 && s_axis_tdata <= 8'h5A) begin
            low_byte = s_axis_tdata + 8'h20;
        end
        // byte taken as signed char
        byte_ext = {{56{low_byte[7]}}, low_byte};
    end

    // hash*33 + byte, and the word close decision
    always_comb begin
        hash_mid   = r_hash;
        inside_mid = r_inside;
        if (active && is_word_byte) begin
            hash_mid   = (r_hash << 5) + r_hash + byte_ext;
            inside_mid = 1'b1;
        end
        close_now = (active && is_space) || s_axis_tlast;
        word_emit = close_now && inside_mid && (r_word_cnt < word_lim);
        cnt_after = r_word_cnt + MAX_WORDS_W'(word_emit);
    end

    // results of this byte
    always_comb begin
        res_word.kind  = RES_WORD;
        res_word.hash  = hash_mid;
        res_word.count = cnt_after;
        res_word.last  = !s_axis_tlast;

        res_count.kind  = RES_COUNT;
        res_count.hash  = '0;
        res_count.count = cnt_after;
        res_count.last  = 1'b1;

        push_n  = 2'd0;
        push_d0 = res_count;
        push_d1 = res_count;
        if (accept) begin
            if (word_emit) begin
                push_d0 = res_word;
            end
            push_n = {1'b0, word_emit} + {1'b0, s_axis_tlast};
        end
    end

    // next review state
    always_comb begin
        n_hash     = r_hash;
        n_word_cnt = r_word_cnt;
        n_byte_cnt = r_byte_cnt;
        n_closed   = r_closed;
        n_inside   = r_inside;
        if (accept) begin
            if (s_axis_tlast) begin
                n_hash     = HASH_SEED;
                n_word_cnt = '0;
                n_byte_cnt = '0;
                n_closed   = 1'b0;
                n_inside   = 1'b0;
            end else begin
                n_word_cnt = cnt_after;
                if (close_now) begin
                    n_hash   = HASH_SEED;
                    n_inside = 1'b0;
                end else begin
                    n_hash   = hash_mid;
                    n_inside = inside_mid;
                end
                if (active) begin
                    n_byte_cnt = r_byte_cnt + MAX_LENGTH_W'(1);
                    if (s_axis_tdata == CHAR_NUL) begin
                        n_closed = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= HASH_SEED;
            r_word_cnt <= '0;
            r_byte_cnt <= '0;
            r_closed   <= 1'b0;
            r_inside   <= 1'b0;
        end else begin
            r_hash     <= n_hash;
            r_word_cnt <= n_word_cnt;
            r_byte_cnt <= n_byte_cnt;
            r_closed   <= n_closed;
            r_inside   <= n_inside;
        end
    end

    // config writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_words  <= MAX_WORDS_RST;
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MAX_WORDS:  r_max_words  <= i_cfg_wdata[MAX_WORDS_W-1:0];
                REG_MAX_LENGTH: r_max_length <= i_cfg_wdata[MAX_LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    wth_result_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_n  (push_n),
        .i_push_d0 (push_d0),
        .i_push_d1 (push_d1),
        .i_pop     (m_axis_tready),
        .o_valid   (q_valid),
        .o_data    (q_data),
        .o_level   (q_level)
    );

    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = {7'd0, q_data.count, q_data.hash};
    assign m_axis_tuser  = q_data.kind;
    assign m_axis_tlast  = q_data.last;

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tlast) |=>
            (r_word_cnt == '0 && !r_inside && !r_closed && r_hash == HASH_SEED))
        else $error("review state not cleared after end of text");

    a_eot_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tlast) |-> (push_n != 2'd0))
        else $error("end of text without count result");

    a_closed_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_closed && !(accept && s_axis_tlast)) |=> r_closed)
        else $error("text closed flag dropped mid-review");

endmodule
`default_nettype wire

// ----- design/wth_result_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wth_result_fifo
// Small result queue, up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module wth_result_fifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [1:0]           i_push_n,
    input  wire wth_pkg::t_result     i_push_d0,
    input  wire wth_pkg::t_result     i_push_d1,
    input  wire logic                 i_pop,
    output wire logic                 o_valid,
    output wire wth_pkg::t_result     o_data,
    output wire logic [$clog2(wth_pkg::FIFO_DEPTH+1)-1:0] o_level
);
    import wth_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int LW = $clog2(FIFO_DEPTH+1);

    t_result         r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [LW-1:0]   r_level, n_level;
    logic            pop_ok;

    assign pop_ok = i_pop && (r_level != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr + PW'(i_push_n);
        n_rd_ptr = r_rd_ptr + PW'(pop_ok);
        n_level  = r_level + LW'(i_push_n) - LW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push_d0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[r_wr_ptr + PW'(1)] <= i_push_d1;
        end
    end

    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_level = r_level;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level == '0 || r_level == LW'(FIFO_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with level");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_level > LW'(FIFO_DEPTH - 2)) |-> (i_push_n == 2'd0))
        else $error("push into a queue without two free entries");

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for word_token_hasher_core: streams review text
// (directed corner bytes, then random reviews and noise) under several
// max_words / max_length settings, predicts every word hash and word count
// in step with each accepted byte, and compares the result stream field by
// field.
// ----------------------------------------------------------------------------
module tb;
    import wth_pkg::*;

    localparam int  QUIET_LIMIT = 4000;     // cycles with no request moving
    localparam int  HOLD_CYCLES = 300;      // long receiver hold-off
    localparam logic [12:0] TEXT_CLOSED = 13'h1FFF;

    typedef struct packed {
        logic [7:0] b;
        logic       eot;
    } t_text_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire [79:0]  m_axis_tdata;
    wire         m_axis_tuser;
    wire         m_axis_tlast;

    word_token_hasher_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    t_text_item text_backlog[$];     // bytes waiting to be offered
    t_result    awaited_results[$];  // predicted results, oldest first
    int         src_gap_pct = 25;
    int         snk_gap_pct = 25;
    int         hold_requests = 0;
    int         n_err = 0;

    // Predictor copy of the review state and the two registers
    logic [63:0] h_run = HASH_SEED;
    logic [8:0]  words_out = '0;
    logic [12:0] bytes_seen = '0;
    logic        in_word = 1'b0;
    logic [8:0]  cfg_words = MAX_WORDS_RST;
    logic [12:0] cfg_len = MAX_LENGTH_RST;

    // Results produced by the byte being predicted (at most two)
    t_result out_res[2];
    int      out_n;

    // ------------------------------------------------------------------
    // Word hash predictor
    // ------------------------------------------------------------------
    function automatic int word_cap();
        return (cfg_words > WORD_LIMIT_MAX_DEF) ? WORD_LIMIT_MAX_DEF : int'(cfg_words);
    endfunction

    function automatic int length_cap();
        return (cfg_len > LENGTH_LIMIT_MAX_DEF) ? LENGTH_LIMIT_MAX_DEF : int'(cfg_len);
    endfunction

    // Punctuation is dropped silently: no word start, no word end.
    function automatic logic is_dropped_mark(input logic [7:0] c);
        if (c < 8'h21 || c > 8'h7E)
            return 1'b0;
        if (c <= 8'h2F || (c >= 8'h3A && c <= 8'h40))
            return 1'b1;
        return (c >= 8'h5B && c <= 8'h60) || c >= 8'h7B;
    endfunction

    function automatic void stage_result(input logic kind, input logic [63:0] h,
                                         input logic [8:0] cnt);
        out_res[out_n].kind  = kind;
        out_res[out_n].hash  = h;
        out_res[out_n].count = cnt;
        out_res[out_n].last  = 1'b0;
        out_n++;
    endfunction

    function automatic void close_open_word();
        if (in_word) begin
            if (words_out < word_cap()) begin
                words_out = words_out + 9'd1;
                stage_result(RES_WORD, h_run, words_out);
            end
            h_run   = HASH_SEED;
            in_word = 1'b0;
        end
    endfunction

    function automatic void hash_text_byte(input logic [7:0] raw, input logic eot);
        logic [7:0] c;
        t_result    r;
        c     = raw;
        out_n = 0;
        if (bytes_seen < length_cap()) begin
            bytes_seen = bytes_seen + 13'd1;
            if (c == CHAR_NUL) begin
                // string terminator: rest of the review is ignored
                bytes_seen = TEXT_CLOSED;
            end else if (c == CHAR_SPACE) begin
                close_open_word();
            end else if (!is_dropped_mark(c)) begin
                if (c >= 8'h41 && c <= 8'h5A)
                    c = c + 8'h20;
                // hash*33 + sign-extended char, wrapping at 64 bits
                h_run   = (h_run << 5) + h_run + {{56{c[7]}}, c};
                in_word = 1'b1;
            end
        end
        if (eot) begin
            close_open_word();
            stage_result(RES_COUNT, 64'd0, words_out);
            h_run      = HASH_SEED;
            words_out  = '0;
            bytes_seen = '0;
            in_word    = 1'b0;
        end
        for (int k = 0; k < out_n; k++) begin
            r      = out_res[k];
            r.last = (k == out_n - 1);
            awaited_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers the backlog, holds each request until taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : text_driver
        t_text_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                hash_text_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (text_backlog.size() != 0 && $urandom_range(0, 99) >= src_gap_pct) begin
                    nxt = text_backlog.pop_front();
                    s_axis_tdata  <= nxt.b;
                    s_axis_tlast  <= nxt.eot;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver ready; a hold request keeps the receiver
    // quiet until hold_left runs down, so the result queue backs up into s_axis.
    // ------------------------------------------------------------------
    int hold_left = 0;
    int holds_done = 0;

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    if (n_err < 10)
                        $display("unexpected result: kind %0d hash %h count %0d last %0d",
                                 m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[72:64],
                                 m_axis_tlast);
                    n_err++;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.kind !== m_axis_tuser || want.hash !== m_axis_tdata[63:0] ||
                        want.count !== m_axis_tdata[72:64] || want.last !== m_axis_tlast) begin
                        if (n_err < 10) begin
                            $write("mismatch (exp/got): kind %0d/%0d hash %h/%h ",
                                   want.kind, m_axis_tuser, want.hash, m_axis_tdata[63:0]);
                            $display("count %0d/%0d last %0d/%0d",
                                     want.count, m_axis_tdata[72:64], want.last,
                                     m_axis_tlast);
                        end
                        n_err++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (holds_done < hold_requests) begin
                holds_done    <= holds_done + 1;
                hold_left     <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= snk_gap_pct);
            end
        end
    end

    // Watchdog: too long without any request moving on either side
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void queue_byte(input logic [7:0] b, input logic eot);
        t_text_item it;
        it.b   = b;
        it.eot = eot;
        text_backlog.push_back(it);
    endfunction

    function automatic logic [7:0] pick_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'(8'h61 + $urandom_range(0, 25));   // a-z
        if (r < 65) return 8'(8'h41 + $urandom_range(0, 25));   // A-Z
        if (r < 75) return 8'($urandom_range(8'h21, 8'h7E));    // any printable
        if (r < 83) return 8'(8'h30 + $urandom_range(0, 9));    // digits
        if (r < 92) return 8'($urandom_range(8'h80, 8'hFF));    // high half
        if (r < 97) return 8'($urandom_range(8'h01, 8'h1F));    // control
        return 8'h7F;
    endfunction

    // One well-formed review; sometimes a NUL cuts it short
    function automatic void add_review(input int n_words);
        int   len;
        logic with_nul;
        logic [7:0] c;
        with_nul = ($urandom_range(0, 7) == 0);
        for (int w = 0; w < n_words; w++) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                c = pick_text_char();
                if (with_nul && $urandom_range(0, 15) == 0)
                    c = CHAR_NUL;
                queue_byte(c, 1'b0);
            end
            if (w != n_words - 1 || $urandom_range(0, 2) == 0) begin
                len = $urandom_range(1, 2);
                for (int k = 0; k < len; k++)
                    queue_byte(CHAR_SPACE, 1'b0);
            end
        end
        case ($urandom_range(0, 3))
            0: queue_byte(8'(8'h61 + $urandom_range(0, 25)), 1'b1);
            1: queue_byte(CHAR_SPACE, 1'b1);
            2: queue_byte(8'h2E, 1'b1);
            default: queue_byte(pick_text_char(), 1'b1);
        endcase
    endfunction

    // Mostly reviews, with bursts of raw noise bytes in between
    function automatic void add_text(input int n_items);
        int goal;
        int burst;
        goal = text_backlog.size() + n_items;
        while (text_backlog.size() < goal) begin
            if ($urandom_range(0, 99) < 85) begin
                add_review($urandom_range(1, 6));
            end else begin
                burst = $urandom_range(1, 4);
                for (int k = 0; k < burst; k++)
                    queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
        end
    endfunction

    // Wait for the block to go idle, with a margin for result-less bytes
    task automatic settle();
        while (text_backlog.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= CFG_DATA_W'(val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_MAX_WORDS)
            cfg_words = 9'(val);
        else if (idx == REG_MAX_LENGTH)
            cfg_len = 13'(val);
    endtask

    task automatic set_limits(input int words, input int len);
        write_reg(REG_MAX_WORDS, words);
        write_reg(REG_MAX_LENGTH, len);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes at reset limits: case folding, sign extension of
        // high bytes, every punctuation range edge, DEL and control bytes
        // as word bytes, double space, NUL truncation, end of text on an
        // ignored byte, an empty review.
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h7A, 1'b0);
        queue_byte(8'h21, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(CHAR_SPACE, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h2F, 1'b0);
        queue_byte(8'h3A, 1'b0);
        queue_byte(CHAR_SPACE, 1'b0);
        queue_byte(CHAR_SPACE, 1'b0);
        queue_byte(8'h40, 1'b0);
        queue_byte(8'h5B, 1'b0);
        queue_byte(8'h60, 1'b0);
        queue_byte(8'h7B, 1'b0);
        queue_byte(8'h7E, 1'b0);
        queue_byte(8'h5A, 1'b1);
        queue_byte(8'h71, 1'b0);
        queue_byte(CHAR_NUL, 1'b0);
        queue_byte(8'h72, 1'b0);
        queue_byte(CHAR_SPACE, 1'b1);
        queue_byte(CHAR_NUL, 1'b1);
        queue_byte(8'h6D, 1'b1);
        settle();

        // one word per review: limit reached early
        set_limits(1, 4096);
        add_text(60);
        settle();

        // short texts truncate most reviews
        set_limits(3, 20);
        add_text(80);
        settle();

        // no hashes at all, one byte per review
        set_limits(0, 1);
        add_text(30);
        settle();

        // above the caps, unknown indexes dropped; full speed on the input
        // with a long receiver hold-off; ends with a word left open
        set_limits(511, 8191);
        write_reg(2'd2, 1);
        write_reg(2'd3, 8191);
        src_gap_pct = 0;
        snk_gap_pct = 0;
        hold_requests = 1;
        add_text(150);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        settle();

        // length 0 mid-review: every byte ignored, end of text still closes
        src_gap_pct = 25;
        snk_gap_pct = 25;
        set_limits(256, 0);
        add_text(20);
        settle();

        set_limits(2, 13);
        add_text(60);
        settle();

        set_limits(256, 4096);
        add_text(100);
        settle();

        n_err += awaited_results.size();
        if (n_err == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/wth_pkg.sv
design/wth_result_fifo.sv
design/word_token_hasher_core.sv
dv/tb.sv
